// ===== rtl/gtg_pkg.sv =====
// shared types, constants and the arctangent table of the go-to-goal controller
`timescale 1ns / 1ps
`default_nettype none

package gtg_pkg;

   // cordic datapath widths: offsets are 17 bit, growth and rotation need headroom
   localparam int XY_W = 20;
   localparam int Z_W  = 17;

   localparam logic signed [Z_W-1:0] HALF_PI_Q13     = 17'sd12868;
   localparam logic [15:0]           CORDIC_COMP_Q16 = 16'd39797;
   localparam logic [XY_W:0]         ROUND_HALF_Q16  = 21'd32768;

   // reset values of the control registers
   localparam logic [15:0] TOL_RESET      = 16'd26;
   localparam logic [15:0] LIN_GAIN_RESET = 16'd256;   // 1.0 in Q8.8
   localparam logic [15:0] ANG_GAIN_RESET = 16'd1024;  // 4.0 in Q8.8

   localparam logic [23:0] LIN_MAX = 24'hFF_FFFF;
   localparam logic [23:0] ANG_MAX = 24'h7F_FFFF;
   localparam logic [23:0] ANG_MIN = 24'h80_0000;

   typedef enum logic [2:0] {
      CSR_GOAL_X    = 3'd0,
      CSR_GOAL_Y    = 3'd1,
      CSR_TOLERANCE = 3'd2,
      CSR_LIN_GAIN  = 3'd3,
      CSR_ANG_GAIN  = 3'd4
   } csr_index_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_RUN
   } ctrl_state_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_vec_type;

   typedef struct packed {
      logic [23:0]        linear_speed;
      logic signed [23:0] angular_rate;
      logic               near;
   } result_type;

   // atan(2^-i) in Q2.13, rounded to nearest
   function automatic logic signed [Z_W-1:0] atan_q13(input int unsigned step);
      logic signed [Z_W-1:0] a;
      case (step)
         0:       a = 17'sd6434;
         1:       a = 17'sd3798;
         2:       a = 17'sd2007;
         3:       a = 17'sd1019;
         4:       a = 17'sd511;
         5:       a = 17'sd256;
         6:       a = 17'sd128;
         7:       a = 17'sd64;
         8:       a = 17'sd32;
         9:       a = 17'sd16;
         10:      a = 17'sd8;
         11:      a = 17'sd4;
         12:      a = 17'sd2;
         13:      a = 17'sd1;
         default: a = 17'sd0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/go_to_goal_p_controller.sv =====
// top level of the proportional go-to-goal controller
//
// usage
//   req_ channel: one pose transaction (x, y in Q8.8, heading in Q2.13 radians)
//   rsp_ channel: one command transaction per pose (linear speed, angular
//     rate, arrived flag)
//   csr_ port: write-only goal, tolerance and gain registers; the user must
//     write them only while no transaction is in flight; the block does not
//     enforce it; a goal write clears the arrival latch
// path: a pose passes the entry stage, one cordic cell per step, three post
//   stages, the result-held flag and the rsp_ register before rsp_valid
// poses: a new pose is taken only once the previous result has moved into
//   the rsp_ register, because the arrival latch of one pose decides the
//   result of the next
// stalls: the result waits in the rsp_ register; the next pose is accepted
//   meanwhile and its result waits at the end of the post stages
// reset: registers return to goal (0, 0), tolerance 26, gains 1.0 and 4.0,
//   latch cleared, both channels empty
`timescale 1ns / 1ps
`default_nettype none

module go_to_goal_p_controller
   import gtg_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // pose transactions
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic signed [15:0] req_pose_x,
   input  wire logic signed [15:0] req_pose_y,
   input  wire logic signed [15:0] req_pose_heading,
   // command transactions
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [23:0]            rsp_linear_speed,
   output logic signed [23:0]     rsp_angular_rate,
   output logic                   rsp_arrived,
   // register writes
   input  wire logic              csr_write_en,
   input  wire logic [2:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   // control registers
   logic signed [15:0] goal_x_ff;
   logic signed [15:0] goal_y_ff;
   logic [15:0]        tolerance_ff;
   logic [15:0]        lin_gain_ff;
   logic [15:0]        ang_gain_ff;
   logic               latch_ff;
   logic               latch_in;

   // sequencing
   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           req_fire;
   logic           rsp_load;
   logic           done_ff;

   logic signed [15:0] heading_ff;
   logic signed [16:0] dx;
   logic signed [16:0] dy;

   logic           row_valid;
   cordic_vec_type row_vec;
   logic           post_valid;
   result_type     post_result;

   // response register
   logic               rsp_valid_ff;
   logic [23:0]        rsp_linear_speed_ff;
   logic signed [23:0] rsp_angular_rate_ff;
   logic               rsp_arrived_ff;

   // ----------------------------------------------------------------------
   // offset from pose to goal, exact in 17 bits
   // ----------------------------------------------------------------------
   assign dx = 17'(goal_x_ff) - 17'(req_pose_x);
   assign dy = 17'(goal_y_ff) - 17'(req_pose_y);

   gtg_cordic_row #(
      .STEPS (CORDIC_STEPS)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_fire),
      .dx        (dx),
      .dy        (dy),
      .out_valid (row_valid),
      .out_vec   (row_vec)
   );

   gtg_post u_post (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (row_valid),
      .in_vec       (row_vec),
      .heading      (heading_ff),
      .tolerance    (tolerance_ff),
      .linear_gain  (lin_gain_ff),
      .angular_gain (ang_gain_ff),
      .out_valid    (post_valid),
      .out_result   (post_result)
   );

   // ----------------------------------------------------------------------
   // sequencer: one pose in the row at a time
   // ----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         CTRL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = CTRL_RUN;
            end
         end
         CTRL_RUN: begin
            // hand the finished command over once the response slot frees up
            if (done_ff && (!rsp_valid_ff || rsp_ready)) begin
               rsp_load = 1'b1;
               state_in = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   assign req_fire = req_valid && req_ready;

   // result of the post stages stays put until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else if (post_valid) begin
         done_ff <= 1'b1;
      end else if (rsp_load) begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         heading_ff <= req_pose_heading;
      end
   end

   // ----------------------------------------------------------------------
   // arrival latch and response register
   // ----------------------------------------------------------------------
   always_comb begin
      latch_in = latch_ff;
      if (rsp_load && post_result.near) begin
         latch_in = 1'b1;
      end
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_GOAL_X: latch_in = 1'b0;
            CSR_GOAL_Y: latch_in = 1'b0;
            default:    latch_in = latch_in;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         latch_ff <= latch_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (latch_ff || post_result.near) begin
            // arrived: commands forced to zero
            rsp_linear_speed_ff <= '0;
            rsp_angular_rate_ff <= '0;
            rsp_arrived_ff      <= 1'b1;
         end else begin
            rsp_linear_speed_ff <= post_result.linear_speed;
            rsp_angular_rate_ff <= post_result.angular_rate;
            rsp_arrived_ff      <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_linear_speed = rsp_linear_speed_ff;
   assign rsp_angular_rate = rsp_angular_rate_ff;
   assign rsp_arrived      = rsp_arrived_ff;

   // ----------------------------------------------------------------------
   // register writes, unknown indexes ignored
   // ----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         tolerance_ff <= TOL_RESET;
         lin_gain_ff  <= LIN_GAIN_RESET;
         ang_gain_ff  <= ANG_GAIN_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_GOAL_X:    goal_x_ff    <= csr_wdata;
            CSR_GOAL_Y:    goal_y_ff    <= csr_wdata;
            CSR_TOLERANCE: tolerance_ff <= csr_wdata;
            CSR_LIN_GAIN:  lin_gain_ff  <= csr_wdata;
            CSR_ANG_GAIN:  ang_gain_ff  <= csr_wdata;
            default:       goal_x_ff    <= goal_x_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gtg_cordic_cell.sv =====
// one vectoring cordic iteration with a fixed shift, registered
`timescale 1ns / 1ps
`default_nettype none

module gtg_cordic_cell
   import gtg_pkg::*;
#(
   parameter int STEP = 0
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire cordic_vec_type in_vec,
   output logic                out_valid,
   output cordic_vec_type      out_vec
);

   logic                   valid_ff;
   cordic_vec_type         vec_ff;
   cordic_vec_type         vec_in;
   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;

   always_comb begin
      xs = in_vec.x >>> STEP;
      ys = in_vec.y >>> STEP;
      // y at or above zero turns clockwise
      if (!in_vec.y[XY_W-1]) begin
         vec_in.x = in_vec.x + ys;
         vec_in.y = in_vec.y - xs;
         vec_in.z = in_vec.z + atan_q13(STEP);
      end else begin
         vec_in.x = in_vec.x - ys;
         vec_in.y = in_vec.y + xs;
         vec_in.z = in_vec.z - atan_q13(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

`default_nettype wire

// ===== rtl/gtg_cordic_row.sv =====
// quadrant pre-rotation followed by a row of cordic cells
`timescale 1ns / 1ps
`default_nettype none

module gtg_cordic_row
   import gtg_pkg::*;
#(
   parameter int STEPS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic signed [16:0] dx,
   input  wire logic signed [16:0] dy,
   output logic                   out_valid,
   output cordic_vec_type         out_vec
);

   logic           valid_chain [0:STEPS];
   cordic_vec_type vec_chain   [0:STEPS];

   logic                   entry_valid_ff;
   cordic_vec_type         entry_vec_ff;
   cordic_vec_type         entry_vec_in;
   logic signed [XY_W-1:0] dx_w;
   logic signed [XY_W-1:0] dy_w;

   // left half plane: turn by a quarter so that x starts non-negative
   always_comb begin
      dx_w = XY_W'(dx);
      dy_w = XY_W'(dy);
      entry_vec_in.x = dx_w;
      entry_vec_in.y = dy_w;
      entry_vec_in.z = '0;
      if (dx_w[XY_W-1]) begin
         if (!dy_w[XY_W-1]) begin
            entry_vec_in.x = dy_w;
            entry_vec_in.y = -dx_w;
            entry_vec_in.z = HALF_PI_Q13;
         end else begin
            entry_vec_in.x = -dy_w;
            entry_vec_in.y = dx_w;
            entry_vec_in.z = -HALF_PI_Q13;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         entry_vec_ff <= entry_vec_in;
      end
   end

   assign valid_chain[0] = entry_valid_ff;
   assign vec_chain[0]   = entry_vec_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      gtg_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[i]),
         .in_vec    (vec_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_vec   (vec_chain[i+1])
      );
   end

   assign out_valid = valid_chain[STEPS];
   assign out_vec   = vec_chain[STEPS];

endmodule

`default_nettype wire

// ===== rtl/gtg_post.sv =====
// gain compensation, command products and saturation after the cordic row
`timescale 1ns / 1ps
`default_nettype none

module gtg_post
   import gtg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire cordic_vec_type    in_vec,
   input  wire logic signed [15:0] heading,
   input  wire logic [15:0]       tolerance,
   input  wire logic [15:0]       linear_gain,
   input  wire logic [15:0]       angular_gain,
   output logic                   out_valid,
   output result_type             out_result
);

   localparam int XU_W = XY_W - 1;

   // stage 1: magnitude times compensation, heading error
   logic                   s1_valid_ff;
   logic [XU_W+15:0]       mag_prod_ff;
   logic signed [Z_W:0]    err_ff;
   logic [XU_W-1:0]        x_clamped;

   // stage 2: rounded distance
   logic                   s2_valid_ff;
   logic [XY_W-1:0]        dist_ff;
   logic signed [Z_W:0]    err2_ff;
   logic [XU_W+16:0]       mag_rounded;

   // stage 3: command products
   logic                   s3_valid_ff;
   logic [XY_W+15:0]       lin_prod_ff;
   logic signed [Z_W+17:0] ang_prod_ff;
   logic                   near_ff;

   logic [XY_W+7:0]        lin_shift;
   logic signed [Z_W+9:0]  ang_shift;

   always_comb begin
      x_clamped = in_vec.x[XY_W-1] ? '0 : in_vec.x[XU_W-1:0];
      mag_rounded = (XU_W+17)'(mag_prod_ff) + (XU_W+17)'(ROUND_HALF_Q16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         mag_prod_ff <= (XU_W+16)'(x_clamped) * (XU_W+16)'(CORDIC_COMP_Q16);
         err_ff      <= (Z_W+1)'(in_vec.z) - (Z_W+1)'(heading);
      end
      if (s1_valid_ff) begin
         dist_ff <= XY_W'(mag_rounded >> 16);
         err2_ff <= err_ff;
      end
      if (s2_valid_ff) begin
         lin_prod_ff <= (XY_W+16)'(dist_ff) * (XY_W+16)'(linear_gain);
         ang_prod_ff <= (Z_W+18)'(err2_ff) * (Z_W+18)'($signed({1'b0, angular_gain}));
         near_ff     <= dist_ff <= XY_W'(tolerance);
      end
   end

   // floor divide by 256 and clamp to the 24 bit command range
   always_comb begin
      lin_shift = lin_prod_ff[XY_W+15:8];
      ang_shift = ang_prod_ff[Z_W+17:8];
      if (|lin_shift[XY_W+7:24]) begin
         out_result.linear_speed = LIN_MAX;
      end else begin
         out_result.linear_speed = lin_shift[23:0];
      end
      if (!ang_shift[Z_W+9] && (|ang_shift[Z_W+8:23])) begin
         out_result.angular_rate = ANG_MAX;
      end else if (ang_shift[Z_W+9] && !(&ang_shift[Z_W+8:23])) begin
         out_result.angular_rate = ANG_MIN;
      end else begin
         out_result.angular_rate = ang_shift[23:0];
      end
      out_result.near = near_ff;
   end

   assign out_valid = s3_valid_ff;

endmodule

`default_nettype wire

// ===== verif/go_to_goal_p_controller_checker.sv =====
// checker for the go-to-goal controller: predicts every command and compares it
`timescale 1ns / 1ps
`default_nettype none

module go_to_goal_p_controller_checker
   import gtg_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic signed [15:0] req_pose_x,
   input  wire logic signed [15:0] req_pose_y,
   input  wire logic signed [15:0] req_pose_heading,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [23:0]        rsp_linear_speed,
   input  wire logic signed [23:0] rsp_angular_rate,
   input  wire logic               rsp_arrived,
   input  wire logic               csr_write_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_wdata,
   output int                      fail_count,
   output int                      in_flight
);

   localparam longint QUARTER_TURN = 12868;
   localparam longint MAG_COMP     = 39797;
   localparam longint SPEED_CEIL   = 16777215;
   localparam longint RATE_CEIL    = 8388607;
   localparam longint RATE_FLOOR   = -8388608;
   localparam int     TABLE_LEN    = 24;

   typedef struct packed {
      logic [23:0]        speed;
      logic signed [23:0] rate;
      logic               arrived;
   } command_type;

   command_type expected_commands[$];

   longint arctan_q13 [TABLE_LEN];

   logic signed [15:0] goal_x_q;
   logic signed [15:0] goal_y_q;
   logic [15:0]        tolerance_q;
   logic [15:0]        lin_gain_q;
   logic [15:0]        ang_gain_q;
   logic               at_goal_q;

   initial begin
      arctan_q13 = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                     32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      fail_count = 0;
      in_flight  = 0;
   end

   // command for one pose; sets the arrival latch as a side effect
   function automatic command_type steer_toward_goal(input logic signed [15:0] px,
                                                     input logic signed [15:0] py,
                                                     input logic signed [15:0] hd);
      longint      dx, dy, x, y, z, xs, ys, distance, lin, ang;
      command_type cmd;
      cmd = '{speed: 24'd0, rate: 24'sd0, arrived: 1'b1};
      if (!at_goal_q) begin
         dx = longint'(goal_x_q) - longint'(px);
         dy = longint'(goal_y_q) - longint'(py);
         x = dx;
         y = dy;
         z = 0;
         // fold the left half-plane into the cordic's range
         if (dx < 0) begin
            if (dy >= 0) begin
               x = dy;
               y = -dx;
               z = QUARTER_TURN;
            end else begin
               x = -dy;
               y = dx;
               z = -QUARTER_TURN;
            end
         end
         for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + arctan_q13[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - arctan_q13[i];
            end
         end
         if (x < 0) x = 0;
         distance = (x * MAG_COMP + 32768) >>> 16;
         if (distance <= longint'(tolerance_q)) begin
            at_goal_q = 1'b1;
         end else begin
            lin = (longint'(lin_gain_q) * distance) >>> 8;
            if (lin > SPEED_CEIL) lin = SPEED_CEIL;
            ang = (longint'(ang_gain_q) * (z - longint'(hd))) >>> 8;
            if (ang > RATE_CEIL) ang = RATE_CEIL;
            if (ang < RATE_FLOOR) ang = RATE_FLOOR;
            cmd.speed   = lin[23:0];
            cmd.rate    = ang[23:0];
            cmd.arrived = 1'b0;
         end
      end
      return cmd;
   endfunction

   always @(posedge clock) begin
      command_type want;
      if (reset) begin
         goal_x_q    = 16'sd0;
         goal_y_q    = 16'sd0;
         tolerance_q = 16'd26;
         lin_gain_q  = 16'd256;
         ang_gain_q  = 16'd1024;
         at_goal_q   = 1'b0;
         expected_commands.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_GOAL_X: begin
                  goal_x_q  = csr_wdata;
                  at_goal_q = 1'b0;
               end
               CSR_GOAL_Y: begin
                  goal_y_q  = csr_wdata;
                  at_goal_q = 1'b0;
               end
               CSR_TOLERANCE: tolerance_q = csr_wdata;
               CSR_LIN_GAIN:  lin_gain_q  = csr_wdata;
               CSR_ANG_GAIN:  ang_gain_q  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_commands.size() == 0) begin
               if (fail_count < 10)
                  $display("checker: command transaction with no pose waiting");
               fail_count++;
            end else begin
               want = expected_commands.pop_front();
               if (rsp_linear_speed !== want.speed || rsp_angular_rate !== want.rate ||
                   rsp_arrived !== want.arrived) begin
                  if (fail_count < 10) begin
                     $write("checker: mismatch: expected speed %0d rate %0d arrived %0b,",
                            want.speed, want.rate, want.arrived);
                     $display(" got speed %0d rate %0d arrived %0b",
                              rsp_linear_speed, rsp_angular_rate, rsp_arrived);
                  end
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_commands.push_back(steer_toward_goal(req_pose_x, req_pose_y,
                                                          req_pose_heading));
      end
      in_flight = expected_commands.size();
   end

endmodule

`default_nettype wire

// ===== verif/go_to_goal_p_controller_test.sv =====
// testbench top of the go-to-goal controller: stimulus, handshakes and verdict
`timescale 1ns / 1ps
`default_nettype none

module go_to_goal_p_controller_test
   import gtg_pkg::*;
();

   localparam int STEPS = 16;
   // indexes past the last register, which the block must ignore
   localparam logic [2:0] CSR_SPARE_LO  = 3'd5;
   localparam logic [2:0] CSR_SPARE_MID = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI  = 3'd7;
   localparam int RANDOM_PHASES   = 41;
   localparam int SCATTER_ITEMS   = 30;
   localparam int APPROACH_ITEMS  = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_pose_x       = 16'sd0;
   logic signed [15:0] req_pose_y       = 16'sd0;
   logic signed [15:0] req_pose_heading = 16'sd0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic [23:0]        rsp_linear_speed;
   logic signed [23:0] rsp_angular_rate;
   logic               rsp_arrived;
   logic               csr_write_en     = 1'b0;
   logic [2:0]         csr_index        = 3'd0;
   logic [15:0]        csr_wdata        = 16'd0;

   int fail_count;
   int in_flight;

   // when set, neither side leaves gaps between transactions
   bit no_idle = 1'b0;

   always #5 clock = ~clock;

   go_to_goal_p_controller #(.CORDIC_STEPS(STEPS)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pose_x       (req_pose_x),
      .req_pose_y       (req_pose_y),
      .req_pose_heading (req_pose_heading),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_angular_rate (rsp_angular_rate),
      .rsp_arrived      (rsp_arrived),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   go_to_goal_p_controller_checker #(.CORDIC_STEPS(STEPS)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pose_x       (req_pose_x),
      .req_pose_y       (req_pose_y),
      .req_pose_heading (req_pose_heading),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_angular_rate (rsp_angular_rate),
      .rsp_arrived      (rsp_arrived),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .in_flight        (in_flight)
   );

   // idle cycles before the next transaction on either side
   function automatic int draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 10);
   endfunction

   // keep a computed position inside the q8.8 range
   function automatic logic signed [15:0] clamp16(input int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   // one register write, only ever issued while the block is idle
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // offer one pose transaction and hold it until the block takes it
   task automatic send_pose(input logic signed [15:0] px, input logic signed [15:0] py,
                            input logic signed [15:0] hd);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pose_x       <= px;
      req_pose_y       <= py;
      req_pose_heading <= hd;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering poses until every command has come back
   task automatic drain_commands();
      req_valid <= 1'b0;
      do @(negedge clock); while (in_flight != 0);
      @(posedge clock);
   endtask

   // command side: random back-pressure, one draw per transaction
   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap();
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // watchdog, well beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic signed [15:0] gx16, gy16, px, py, hd;
      int gx, gy, off_x, off_y, kind;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: goal at the origin, tolerance 26, gains 1.0 and 4.0
      // corners of the pose range, one per quadrant of the offset
      send_pose(-16'sd32768, -16'sd32768, 16'sd32767);
      send_pose(16'sd32767, 16'sd32767, -16'sd32768);
      send_pose(16'sd32767, -16'sd32768, 16'sd0);
      send_pose(-16'sd32768, 16'sd32767, -16'sd1);
      // offset straight behind, then straight along y
      send_pose(16'sd100, 16'sd0, 16'sd12868);
      send_pose(16'sd0, -16'sd200, -16'sd12868);
      // just outside the tolerance, then inside it so the latch sets
      send_pose(16'sd27, 16'sd0, 16'sd0);
      send_pose(16'sd10, 16'sd10, 16'sd0);
      // far away again, but the latch holds
      send_pose(-16'sd32768, -16'sd32768, 16'sd0);
      drain_commands();

      // extreme goal, zero tolerance and full gains: the first pose saturates both commands
      write_reg(CSR_GOAL_X, 16'h7FFF);
      write_reg(CSR_GOAL_Y, 16'h8000);
      write_reg(CSR_TOLERANCE, 16'h0000);
      write_reg(CSR_LIN_GAIN, 16'hFFFF);
      write_reg(CSR_ANG_GAIN, 16'hFFFF);
      send_pose(-16'sd32768, 16'sd32767, 16'sd32767);
      send_pose(-16'sd32768, 16'sd32767, -16'sd32768);
      send_pose(16'sd32767, -16'sd32767, 16'sd0);
      // pose exactly on the goal: zero offset arrives even at zero tolerance
      send_pose(16'sd32767, -16'sd32768, 16'sd0);
      drain_commands();

      // non-goal writes must leave the latch set
      write_reg(CSR_TOLERANCE, 16'hFFFF);
      write_reg(CSR_LIN_GAIN, 16'h0001);
      send_pose(16'sd0, 16'sd0, 16'sd0);
      drain_commands();

      // a goal write clears the latch; zero gains give zero commands, not arrival
      write_reg(CSR_GOAL_X, 16'h0000);
      write_reg(CSR_TOLERANCE, 16'h0000);
      write_reg(CSR_LIN_GAIN, 16'h0000);
      write_reg(CSR_ANG_GAIN, 16'h0000);
      write_reg(CSR_SPARE_LO, 16'hFFFF);
      write_reg(CSR_SPARE_MID, 16'h5A5A);
      write_reg(CSR_SPARE_HI, 16'hA5A5);
      send_pose(16'sd32767, 16'sd32767, -16'sd32768);
      send_pose(-16'sd32768, 16'sd32767, 16'sd32767);
      drain_commands();

      // widest tolerance: the longest offset still misses it, a shorter one arrives
      write_reg(CSR_GOAL_X, 16'h8000);
      write_reg(CSR_GOAL_Y, 16'h7FFF);
      write_reg(CSR_TOLERANCE, 16'hFFFF);
      write_reg(CSR_LIN_GAIN, 16'd256);
      write_reg(CSR_ANG_GAIN, 16'd1024);
      send_pose(16'sd32767, -16'sd32768, 16'sd0);
      send_pose(16'sd0, 16'sd0, 16'sd0);
      drain_commands();

      // random phases: new settings each time, scattered poses, then a run
      // towards the goal that ends on it so the latch is reached every phase
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         no_idle = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 7))
            0:       gx16 = -16'sd32768;
            1:       gx16 = 16'sd32767;
            default: gx16 = 16'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 7))
            0:       gy16 = -16'sd32768;
            1:       gy16 = 16'sd32767;
            default: gy16 = 16'($urandom_range(0, 65535));
         endcase
         gx = int'(gx16);
         gy = int'(gy16);
         write_reg(CSR_GOAL_X, gx16);
         write_reg(CSR_GOAL_Y, gy16);
         case ($urandom_range(0, 9))
            0:       write_reg(CSR_TOLERANCE, 16'h0000);
            1:       write_reg(CSR_TOLERANCE, 16'hFFFF);
            2:       write_reg(CSR_TOLERANCE, 16'($urandom_range(0, 65535)));
            default: write_reg(CSR_TOLERANCE, 16'($urandom_range(0, 1023)));
         endcase
         case ($urandom_range(0, 5))
            0:       write_reg(CSR_LIN_GAIN, 16'h0000);
            1:       write_reg(CSR_LIN_GAIN, 16'hFFFF);
            2:       write_reg(CSR_LIN_GAIN, 16'($urandom_range(0, 2048)));
            default: write_reg(CSR_LIN_GAIN, 16'($urandom_range(0, 65535)));
         endcase
         case ($urandom_range(0, 5))
            0:       write_reg(CSR_ANG_GAIN, 16'h0000);
            1:       write_reg(CSR_ANG_GAIN, 16'hFFFF);
            2:       write_reg(CSR_ANG_GAIN, 16'($urandom_range(0, 4096)));
            default: write_reg(CSR_ANG_GAIN, 16'($urandom_range(0, 65535)));
         endcase
         if ($urandom_range(0, 5) == 0)
            write_reg(3'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                      16'($urandom_range(0, 65535)));

         for (int n = 0; n < SCATTER_ITEMS; n++) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
               px = 16'($urandom_range(0, 65535));
               py = 16'($urandom_range(0, 65535));
            end else if (kind < 17) begin
               // close to the goal, around the tolerance
               px = clamp16(gx + int'($urandom_range(0, 1200)) - 600);
               py = clamp16(gy + int'($urandom_range(0, 1200)) - 600);
            end else if (kind == 17) begin
               px = gx16;
               py = 16'($urandom_range(0, 65535));
            end else begin
               px = 16'($urandom_range(0, 65535));
               py = gy16;
            end
            hd = 16'($urandom_range(0, 65535));
            send_pose(px, py, hd);
            // now and then the sender waits for every command to come back
            if (n == SCATTER_ITEMS / 2 && $urandom_range(0, 3) == 0)
               drain_commands();
         end

         off_x = int'($urandom_range(0, 8192)) - 4096;
         off_y = int'($urandom_range(0, 8192)) - 4096;
         for (int s = 0; s < APPROACH_ITEMS; s++) begin
            px = clamp16(gx + off_x * (APPROACH_ITEMS - 1 - s) / (APPROACH_ITEMS - 1));
            py = clamp16(gy + off_y * (APPROACH_ITEMS - 1 - s) / (APPROACH_ITEMS - 1));
            hd = 16'($urandom_range(0, 65535));
            send_pose(px, py, hd);
         end
         drain_commands();
      end

      // let any stray command show up before the verdict
      no_idle = 1'b0;
      repeat (STEPS + 10) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && in_flight == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
